### design/tsl_pkg.sv
// shared types, constants and the arctangent table for the tsl pixel converter
package tsl_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int SUM_BITS    = PIXEL_BITS + 2;
    localparam int CHROMA_BITS = PIXEL_BITS + 3;
    localparam int SQ_BITS     = 2 * PIXEL_BITS + 3;
    localparam int SS_BITS     = 2 * SUM_BITS;
    localparam int LNUM_BITS   = 18;
    localparam int LPROD_BITS  = 37;
    localparam int LIGHT_FRAC  = 28;
    localparam int LIGHT_RECIP = 268436;
    localparam int LIGHT_BIAS  = 500;
    localparam int SAT_SCALE   = 260100;
    localparam int SAT_BITS    = 8;
    localparam int TABLE_LEN   = 24;
    localparam int ANGLE_BITS  = 24;
    localparam int XY_SHIFT    = 32;
    localparam int XY_BITS     = 44;
    localparam int P_BITS      = 44;
    localparam int Q_BITS      = 32;
    localparam int RHS_BITS    = 38;
    localparam int BASE_BITS   = 22;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 24'h400000;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 24'h800000;
    localparam int TINT_ROUND  = 32768;
    localparam int TINT_SHIFT  = 16;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] blue;
        logic [PIXEL_BITS-1:0] green;
        logic [PIXEL_BITS-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [7:0] tint;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } t_tsl;

    typedef struct packed {
        logic                      valid;
        logic                      zero_sum;
        logic                      zero_b;
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic [ANGLE_BITS-1:0]     z;
        logic [RHS_BITS-1:0]       rhs;
        logic [BASE_BITS-1:0]      base;
        logic signed [P_BITS-1:0]  p;
        logic signed [Q_BITS-1:0]  q;
        logic [SAT_BITS-1:0]       k;
        logic [7:0]                light;
    } t_cell_data;

    // atan(2^-i) in turns, 24 fraction bits
    function automatic logic [ANGLE_BITS-1:0] atan_turn(input int unsigned idx);
        case (idx)
            0: return 24'd2097152;
            1: return 24'd1238021;
            2: return 24'd654136;
            3: return 24'd332050;
            4: return 24'd166669;
            5: return 24'd83416;
            6: return 24'd41718;
            7: return 24'd20860;
            8: return 24'd10430;
            9: return 24'd5215;
            10: return 24'd2608;
            11: return 24'd1304;
            12: return 24'd652;
            13: return 24'd326;
            14: return 24'd163;
            15: return 24'd81;
            16: return 24'd41;
            17: return 24'd20;
            18: return 24'd10;
            19: return 24'd5;
            20: return 24'd3;
            21: return 24'd1;
            22: return 24'd1;
            default: return '0;
        endcase
    endfunction

endpackage

### design/tsl_front.sv
// front stages: chromaticity offsets, squares, luma and vector setup
module tsl_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  tsl_pkg::t_pixel       i_pixel,
    output tsl_pkg::t_cell_data   o_data
);

    typedef struct packed {
        logic                                   valid;
        logic [tsl_pkg::SUM_BITS-1:0]           sum;
        logic signed [tsl_pkg::CHROMA_BITS-1:0] a;
        logic signed [tsl_pkg::CHROMA_BITS-1:0] b;
        logic [tsl_pkg::LNUM_BITS-1:0]          lnum;
    } t_s1;

    typedef struct packed {
        logic                                   valid;
        logic                                   zero_sum;
        logic signed [tsl_pkg::CHROMA_BITS-1:0] a;
        logic signed [tsl_pkg::CHROMA_BITS-1:0] b;
        logic [tsl_pkg::SQ_BITS-1:0]            sq;
        logic [tsl_pkg::SS_BITS-1:0]            ss;
        logic [7:0]                             light;
    } t_s2;

    t_s1                 r_s1, n_s1;
    t_s2                 r_s2, n_s2;
    tsl_pkg::t_cell_data r_s3, n_s3;

    logic signed [2*tsl_pkg::CHROMA_BITS-1:0] w_asq, w_bsq;
    logic [tsl_pkg::LPROD_BITS-1:0]           w_lprod;
    logic signed [tsl_pkg::XY_BITS-1:0]       w_xa, w_xb;

    always_comb begin
        n_s1.valid = i_valid;
        n_s1.sum   = tsl_pkg::SUM_BITS'(i_pixel.blue) + tsl_pkg::SUM_BITS'(i_pixel.green)
                   + tsl_pkg::SUM_BITS'(i_pixel.red);
        n_s1.a     = $signed({2'b00, i_pixel.red, 1'b0}) - $signed({3'b000, i_pixel.green})
                   - $signed({3'b000, i_pixel.blue});
        n_s1.b     = $signed({2'b00, i_pixel.green, 1'b0}) - $signed({3'b000, i_pixel.red})
                   - $signed({3'b000, i_pixel.blue});
        n_s1.lnum  = tsl_pkg::LNUM_BITS'(i_pixel.red) * tsl_pkg::LNUM_BITS'(299)
                   + tsl_pkg::LNUM_BITS'(i_pixel.green) * tsl_pkg::LNUM_BITS'(587)
                   + tsl_pkg::LNUM_BITS'(i_pixel.blue) * tsl_pkg::LNUM_BITS'(114)
                   + tsl_pkg::LNUM_BITS'(tsl_pkg::LIGHT_BIAS);
    end

    always_comb begin
        w_asq          = r_s1.a * r_s1.a;
        w_bsq          = r_s1.b * r_s1.b;
        w_lprod        = tsl_pkg::LPROD_BITS'(r_s1.lnum)
                       * tsl_pkg::LPROD_BITS'(tsl_pkg::LIGHT_RECIP);
        n_s2.valid     = r_s1.valid;
        n_s2.zero_sum  = (r_s1.sum == '0);
        n_s2.a         = r_s1.a;
        n_s2.b         = r_s1.b;
        n_s2.sq        = tsl_pkg::SQ_BITS'(w_asq + w_bsq);
        n_s2.ss        = tsl_pkg::SS_BITS'(r_s1.sum) * tsl_pkg::SS_BITS'(r_s1.sum);
        n_s2.light     = w_lprod[tsl_pkg::LIGHT_FRAC +: 8];
    end

    always_comb begin
        w_xb          = tsl_pkg::XY_BITS'(r_s2.b) <<< tsl_pkg::XY_SHIFT;
        w_xa          = tsl_pkg::XY_BITS'(r_s2.a) <<< tsl_pkg::XY_SHIFT;
        n_s3.valid    = r_s2.valid;
        n_s3.zero_sum = r_s2.zero_sum;
        n_s3.zero_b   = (r_s2.b == '0);
        n_s3.rhs      = tsl_pkg::RHS_BITS'(r_s2.sq) * tsl_pkg::RHS_BITS'(tsl_pkg::SAT_SCALE);
        n_s3.base     = tsl_pkg::BASE_BITS'(r_s2.ss) * tsl_pkg::BASE_BITS'(5);
        n_s3.p        = $signed({{(tsl_pkg::P_BITS - tsl_pkg::BASE_BITS){1'b0}}, n_s3.base});
        n_s3.q        = -$signed({{(tsl_pkg::Q_BITS - tsl_pkg::BASE_BITS){1'b0}}, n_s3.base});
        n_s3.k        = '0;
        n_s3.light    = r_s2.light;
        if (r_s2.b < 0) begin
            n_s3.x = -w_xb;
            n_s3.y = -w_xa;
            n_s3.z = tsl_pkg::HALF_TURN;
        end else begin
            n_s3.x = w_xb;
            n_s3.y = w_xa;
            n_s3.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_data = r_s3;

endmodule

### design/tsl_cell.sv
// one cell: a rotation step and, in the first cells, one saturation search bit
module tsl_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tsl_pkg::t_cell_data i_d,
    output tsl_pkg::t_cell_data o_d
);

    tsl_pkg::t_cell_data r_d, n_d;

    always_comb begin
        n_d = i_d;
        if (IDX < tsl_pkg::TABLE_LEN) begin
            if (i_d.y < 0) begin
                n_d.x = i_d.x - (i_d.y >>> IDX);
                n_d.y = i_d.y + (i_d.x >>> IDX);
                n_d.z = i_d.z - tsl_pkg::atan_turn(IDX);
            end else begin
                n_d.x = i_d.x + (i_d.y >>> IDX);
                n_d.y = i_d.y - (i_d.x >>> IDX);
                n_d.z = i_d.z + tsl_pkg::atan_turn(IDX);
            end
        end
    end

    generate
        if (IDX < tsl_pkg::SAT_BITS) begin : g_sat
            localparam int M = tsl_pkg::SAT_BITS - 1 - IDX;
            logic signed [tsl_pkg::P_BITS-1:0] w_qx, w_bx, w_rx, w_trial;
            logic                              w_take;
            tsl_pkg::t_cell_data               w_next;

            // trial odd value (2k-1) squared times base, built from the running terms
            always_comb begin
                w_qx    = $signed({{(tsl_pkg::P_BITS - tsl_pkg::Q_BITS){i_d.q[tsl_pkg::Q_BITS-1]}},
                                   i_d.q});
                w_bx    = $signed({{(tsl_pkg::P_BITS - tsl_pkg::BASE_BITS){1'b0}}, i_d.base});
                w_rx    = $signed({{(tsl_pkg::P_BITS - tsl_pkg::RHS_BITS){1'b0}}, i_d.rhs});
                w_trial = i_d.p + (w_qx <<< (M + 2)) + (w_bx <<< (2 * M + 2));
                w_take  = (w_trial <= w_rx);
                w_next  = n_d;
                if (w_take) begin
                    w_next.p    = w_trial;
                    w_next.q    = i_d.q + (tsl_pkg::Q_BITS'(i_d.base) <<< (M + 1));
                    w_next.k[M] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d.valid <= 1'b0;
                end else if (i_en) begin
                    r_d <= w_next;
                end
            end

            a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (i_en && i_d.valid && (i_d.k[M:0] == '0)) |=>
                    (M == 0 || (r_d.k & tsl_pkg::SAT_BITS'((1 << M) - 1)) == '0))
                else $error("saturation bits below the search bit were set");
        end else begin : g_plain
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d.valid <= 1'b0;
                end else if (i_en) begin
                    r_d <= n_d;
                end
            end
        end
    endgenerate

    assign o_d = r_d;

endmodule

### design/tsl_out.sv
// result stage: tint rounding, special cases and the output register
module tsl_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsl_pkg::t_cell_data i_d,
    input  logic                i_ready,
    output logic                o_en,
    output logic                o_valid,
    output tsl_pkg::t_tsl       o_tsl
);

    logic                           r_valid;
    tsl_pkg::t_tsl                  r_tsl, n_tsl;
    logic [tsl_pkg::ANGLE_BITS-1:0] w_turn;
    logic [tsl_pkg::ANGLE_BITS:0]   w_round;
    logic [8:0]                     w_code;

    assign o_en = !r_valid || i_ready;

    always_comb begin
        w_turn  = tsl_pkg::QUARTER_TURN + i_d.z;
        w_round = {1'b0, w_turn} + (tsl_pkg::ANGLE_BITS + 1)'(tsl_pkg::TINT_ROUND);
        w_code  = w_round[tsl_pkg::TINT_SHIFT +: 9];
        n_tsl.lightness = i_d.light;
        if (i_d.zero_sum) begin
            n_tsl.tint       = '0;
            n_tsl.saturation = '0;
        end else begin
            n_tsl.saturation = i_d.k;
            if (i_d.zero_b) begin
                n_tsl.tint = '0;
            end else if (w_code[8]) begin
                n_tsl.tint = 8'hff;
            end else begin
                n_tsl.tint = w_code[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_d.valid;
            r_tsl   <= n_tsl;
        end
    end

    assign o_valid = r_valid;
    assign o_tsl   = r_tsl;

    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_en && i_d.valid && i_d.zero_sum) |=>
            (r_tsl.tint == '0 && r_tsl.saturation == '0))
        else $error("black pixel gave nonzero tint or saturation");

    a_zero_g_tint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_en && i_d.valid && i_d.zero_b) |=> (r_tsl.tint == '0))
        else $error("zero green offset gave nonzero tint");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_tsl)))
        else $error("held result changed or dropped");

endmodule

### design/rgb_to_tsl_pixel.sv
// top level: rgb pixel to tint, saturation, lightness conversion pipeline
//
//   channel   valid     ready     payload
//   request   i_valid   o_ready   i_pixel (blue, green, red)
//   result    o_valid   i_ready   o_tsl (tint, saturation, lightness)
//
// one pixel per cycle while the result side is not stalled
// the row of rotation cells has one cell per angle stage
// synchronous reset clears all valid bits, payload is not cleared
// a held result freezes the whole pipeline; o_ready drops only then
module rgb_to_tsl_pixel #(
    parameter int ANGLE_STAGES = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tsl_pkg::t_pixel i_pixel,
    output logic            o_valid,
    input  logic            i_ready,
    output tsl_pkg::t_tsl   o_tsl
);

    logic                w_en;
    tsl_pkg::t_cell_data w_chain [0:ANGLE_STAGES];

    assign o_ready = w_en;

    tsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_data  (w_chain[0])
    );

    generate
        for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cell
            tsl_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_d     (w_chain[g]),
                .o_d     (w_chain[g+1])
            );
        end
    endgenerate

    tsl_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_chain[ANGLE_STAGES]),
        .i_ready (i_ready),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_tsl   (o_tsl)
    );

endmodule

### test/rgb_to_tsl_pixel_tb.sv
// testbench for rgb_to_tsl_pixel: random and directed pixels checked against a tsl predictor
module rgb_to_tsl_pixel_tb;

    localparam int STAGES = 14;
    localparam int LATENCY = STAGES + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS = 1700;

    class tsl_scoreboard;
        tsl_pkg::t_tsl pending[$];
        int errors;

        function logic [7:0] tint_of(longint a, longint b);
            longint x, y, z, xs, ys, t, code;
            if (b == 0) return 8'd0;
            x = b <<< 32;
            y = a <<< 32;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = longint'(tsl_pkg::HALF_TURN);
            end
            for (int i = 0; i < STAGES && i < tsl_pkg::TABLE_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y < 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(tsl_pkg::atan_turn(i));
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(tsl_pkg::atan_turn(i));
                end
            end
            t = (longint'(tsl_pkg::QUARTER_TURN) + z) & 64'hFFFFFF;
            code = (t + tsl_pkg::TINT_ROUND) >> tsl_pkg::TINT_SHIFT;
            return code > 255 ? 8'd255 : code[7:0];
        endfunction

        function logic [7:0] saturation_of(longint a, longint b, longint sum);
            longint rhs, base, o;
            logic [7:0] k;
            rhs = 4 * 65025 * (a * a + b * b);
            base = 5 * sum * sum;
            k = 0;
            for (int c = 1; c <= 255; c++) begin
                o = 2 * c - 1;
                if (o * o * base <= rhs) k = c[7:0];
                else break;
            end
            return k;
        endfunction

        function void note_pixel(tsl_pkg::t_pixel px);
            longint sum, a, b, n, d, light;
            tsl_pkg::t_tsl res;
            sum = px.blue + px.green + px.red;
            n = 299 * px.red + 587 * px.green + 114 * px.blue;
            d = 1000 * 255;
            light = (2 * 255 * n + d) / (2 * d);
            res.lightness = light > 255 ? 8'd255 : light[7:0];
            res.tint = 0;
            res.saturation = 0;
            if (sum != 0) begin
                a = 3 * longint'(px.red) - sum;
                b = 3 * longint'(px.green) - sum;
                res.tint = tint_of(a, b);
                res.saturation = saturation_of(a, b, sum);
            end
            pending.push_back(res);
        endfunction

        function void check_result(tsl_pkg::t_tsl got);
            tsl_pkg::t_tsl want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.tint !== want.tint) begin
                $display("%0t tint expected %0d actual %0d", $time, want.tint, got.tint);
                errors++;
            end
            if (got.saturation !== want.saturation) begin
                $display("%0t saturation expected %0d actual %0d", $time,
                    want.saturation, got.saturation);
                errors++;
            end
            if (got.lightness !== want.lightness) begin
                $display("%0t lightness expected %0d actual %0d", $time,
                    want.lightness, got.lightness);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic i_ready = 0;
    tsl_pkg::t_pixel i_pixel = '0;
    logic o_ready, o_valid;
    tsl_pkg::t_tsl o_tsl;

    tsl_scoreboard board = new();
    logic calm = 0;
    bit sending_done = 0;
    int idle_cycles = 0;

    rgb_to_tsl_pixel #(.ANGLE_STAGES(STAGES)) dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) board.note_pixel(i_pixel);
        if (i_rst_n && o_valid && i_ready) board.check_result(o_tsl);
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_to_tsl_pixel verification failed");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 15);
                i_ready <= 0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk);
        end
    end

    task automatic send_pixel(tsl_pkg::t_pixel px);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic tsl_pkg::t_pixel rand_pixel();
        tsl_pkg::t_pixel px;
        int mode;
        mode = $urandom_range(0, 9);
        px = 24'($urandom);
        if (mode == 0) begin
            px.green = ($urandom_range(0, 1) ? px.red : px.blue);
            // bias toward 3G equals sum: green equals mean of red and blue
            px.red = px.green + ($urandom_range(0, 1) ? 8'd0 : 8'd0);
            px.blue = px.green;
        end else if (mode == 1) begin
            px.green = 8'($urandom_range(0, 127));
            px.red = px.green + 8'($urandom_range(0, 127));
            px.blue = 8'(2 * px.green - px.red);
            if (px.red < px.green || px.green * 2 < px.red) px.blue = px.green;
        end else if (mode == 2) begin
            px = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                  8'($urandom_range(0, 3))};
        end
        return px;
    endfunction

    initial begin
        tsl_pkg::t_pixel dir[$];
        dir = '{'{0, 0, 0}, '{255, 255, 255}, '{0, 0, 255}, '{0, 255, 0},
                '{255, 0, 0}, '{255, 255, 0}, '{0, 255, 255}, '{255, 0, 255},
                '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}, '{100, 100, 100},
                '{10, 20, 30}, '{30, 20, 10}, '{128, 128, 127}, '{170, 85, 0},
                '{0, 85, 170}, '{85, 85, 85}, '{254, 1, 255}, '{1, 254, 0}};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir[i]) send_pixel(dir[i]);
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == RANDOM_PIXELS - 200) calm <= 1;
            send_pixel(rand_pixel());
        end
        i_valid <= 0;
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("rgb_to_tsl_pixel verification clean");
        else
            $display("rgb_to_tsl_pixel verification failed");
        $finish;
    end
endmodule
